// ----- sv/lrut_pkg.sv -----
// Shared types and constants for the LRU page replacement tracker.
`timescale 1ns / 1ps

package lrut_pkg;

  localparam int COUNT_W = 32;
  localparam int CFG_W   = 4;
  localparam int FILL_W  = 4;

  // Per-cell update controls, driven by the top level.
  typedef struct packed {
    logic step;
    logic evict;
    logic load;
  } lrut_cell_ctl_t;

endpackage

// ----- sv/lrut_cell.sv -----
// One recency slot: holds a page, compares it, and shifts toward the LRU end.
`timescale 1ns / 1ps

module lrut_cell
  import lrut_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  lrut_cell_ctl_t       ctl,
  input  logic                 valid,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic [PAGE_BITS-1:0] neighbor_page,
  input  logic                 seen_in,
  output logic                 seen_out,
  output logic [PAGE_BITS-1:0] page_out
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 shift;

  assign seen_out = seen_in | (valid && (page_q == page_in));
  // A hit at or below this slot, or an eviction, pulls the younger neighbor in.
  assign shift    = seen_out | ctl.evict;
  assign page_out = page_q;

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.load) begin
        page_q <= page_in;
      end else if (shift) begin
        page_q <= neighbor_page;
      end
    end
  end

endmodule

// ----- sv/lru_page_replacement_tracker.sv -----
// Top level: fully associative LRU page tracker built as a chain of cells.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | in        | in_valid / in_stall    | page, last_access
//  out     | out       | out_valid / out_stall  | hit, evicted_valid, evicted_page,
//          |           |                        | hit_count, miss_count, frames_filled
//  cfg     | in        | cfg_wr_en              | cfg_wr_data (frames_in_use)
//
// One transaction per cycle while in_stall is low: every cell compares in parallel
// and shifts in the same cycle, and the result is registered in the output register.
// Reset clears the counts, the fill level and sets frames_in_use to 8.
// While the output register holds an untaken result and out_stall is high,
// in_stall is raised; otherwise a new transaction can be taken every cycle.
`timescale 1ns / 1ps

module lru_page_replacement_tracker
  import lrut_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 last_access,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [COUNT_W-1:0]   hit_count,
  output logic [COUNT_W-1:0]   miss_count,
  output logic [FILL_W-1:0]    frames_filled,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int CW   = $clog2(FRAMES + 1);
  localparam int CAPW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]   frames_in_use;
  logic [CW-1:0]      filled;
  logic [CW-1:0]      filled_next;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] hit_total_next;
  logic [COUNT_W-1:0] miss_total;
  logic [COUNT_W-1:0] miss_total_next;

  logic                 step;
  logic                 hit_now;
  logic                 evict_now;
  logic [CAPW-1:0]      cap;
  logic [CAPW-1:0]      fiu_ext;
  logic [CW-1:0]        top_idx;

  logic [FRAMES:0]         seen;
  logic [PAGE_BITS-1:0]    cell_page [FRAMES+1];
  lrut_cell_ctl_t          cell_ctl  [FRAMES];

  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  assign seen[0]           = 1'b0;
  assign cell_page[FRAMES] = '0;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      assign cell_ctl[g].step  = step;
      assign cell_ctl[g].evict = evict_now;
      assign cell_ctl[g].load  = (top_idx == CW'(g));

      lrut_cell #(
        .PAGE_BITS(PAGE_BITS)
      ) u_cell (
        .clk          (clk),
        .ctl          (cell_ctl[g]),
        .valid        (filled > CW'(g)),
        .page_in      (page),
        .neighbor_page(cell_page[g+1]),
        .seen_in      (seen[g]),
        .seen_out     (seen[g+1]),
        .page_out     (cell_page[g])
      );
    end
  endgenerate

  assign hit_now = seen[FRAMES];

  // Capacity clamped to 1..FRAMES.
  always_comb begin
    fiu_ext = CAPW'(frames_in_use);
    priority if (fiu_ext == '0) begin
      cap = CAPW'(1);
    end else if (fiu_ext > CAPW'(FRAMES)) begin
      cap = CAPW'(FRAMES);
    end else begin
      cap = fiu_ext;
    end
  end

  assign evict_now = ~hit_now && (CAPW'(filled) >= cap);
  assign top_idx   = (hit_now | evict_now) ? (filled - CW'(1)) : filled;

  always_comb begin
    filled_next     = filled;
    hit_total_next  = hit_total;
    miss_total_next = miss_total;
    if (hit_now) begin
      if (hit_total != '1) begin
        hit_total_next = hit_total + COUNT_W'(1);
      end
    end else begin
      if (miss_total != '1) begin
        miss_total_next = miss_total + COUNT_W'(1);
      end
      if (!evict_now && filled < CW'(FRAMES)) begin
        filled_next = filled + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(8);
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled     <= '0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (step) begin
      if (last_access) begin
        filled     <= '0;
        hit_total  <= '0;
        miss_total <= '0;
      end else begin
        filled     <= filled_next;
        hit_total  <= hit_total_next;
        miss_total <= miss_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hit           <= hit_now;
      evicted_valid <= evict_now;
      evicted_page  <= evict_now ? cell_page[0] : '0;
      hit_count     <= hit_total_next;
      miss_count    <= miss_total_next;
      frames_filled <= FILL_W'(filled_next);
    end
  end

endmodule

// ----- sv/lrut_checker.sv -----
// Port-level checks for the LRU page replacement tracker, bound to the top level.
`timescale 1ns / 1ps

module lrut_checker
  import lrut_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 hit,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page,
  input logic [COUNT_W-1:0]   hit_count,
  input logic [COUNT_W-1:0]   miss_count
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit ? (hit_count != '0) : (miss_count != '0)))
    else $error("count does not include this transaction");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit_count) && $stable(miss_count)))
    else $error("stalled result changed");

endmodule

bind lru_page_replacement_tracker lrut_checker #(
  .PAGE_BITS(PAGE_BITS)
) u_lrut_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .hit          (hit),
  .evicted_valid(evicted_valid),
  .evicted_page (evicted_page),
  .hit_count    (hit_count),
  .miss_count   (miss_count)
);
